/* sv/alsd_pkg.sv */
// shared types, codes and constants of the addressable led strip driver
package alsd_pkg;

    localparam int MAX_LEDS_DEF = 256;
    localparam int ROW_W        = 24;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    // operation codes of a command transaction
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_SET   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_SHOW  = 2'd3;

    // color order codes
    localparam logic [1:0] ORDER_RGB = 2'd0;
    localparam logic [1:0] ORDER_GRB = 2'd1;
    localparam logic [1:0] ORDER_BGR = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_ORDER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LATCH       = 3'd6;

    // register reset values
    localparam logic [1:0]  RST_COLOR_ORDER = 2'd0;
    localparam logic [8:0]  RST_LED_COUNT   = 9'd0;
    localparam logic [7:0]  RST_ZERO_HIGH   = 8'd3;
    localparam logic [7:0]  RST_ZERO_LOW    = 8'd8;
    localparam logic [7:0]  RST_ONE_HIGH    = 8'd7;
    localparam logic [7:0]  RST_ONE_LOW     = 8'd6;
    localparam logic [15:0] RST_LATCH       = 16'd600;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_PRE  = 4'b0010,
        PH_BITS = 4'b0100,
        PH_POST = 4'b1000
    } phase_t;

    typedef struct packed {
        logic exec;
        logic load_row;
        logic clr_step;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_fetch;
        logic start_clear;
        logic clr_last;
    } dp_status_t;

endpackage

/* sv/alsd_if.sv */
// command and result channel interfaces
interface alsd_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] led_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output op, output led_index, output red, output green,
                    output blue, input ready);
    modport sink (input valid, input op, input led_index, input red, input green,
                  input blue, output ready);
endinterface

interface alsd_res_if;
    logic valid;
    logic ready;
    logic line_level;
    logic busy_res;
    logic rejected;

    modport source (output valid, output line_level, output busy_res, output rejected,
                    input ready);
    modport sink (input valid, input line_level, input busy_res, input rejected,
                  output ready);
endinterface

/* sv/addressable_led_strip_driver.sv */
// top level of the addressable led strip driver
// tick, set and show go from accept through the done state to the registered result; a tick
// that moves to the next led also passes the fetch and load states, for the registered read
// of the frame buffer row; clear steps through the clear state, one frame buffer row written
// per cycle, then the done state; commands are taken only in idle, and the next command is
// taken while a result waits; reset clears the frame buffer before any command
module addressable_led_strip_driver #(
    parameter int MAX_LEDS = alsd_pkg::MAX_LEDS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [alsd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [alsd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    alsd_cmd_if.sink                        cmd,
    alsd_res_if.source                      res
);

    alsd_pkg::ctrl_cmd_t  ctrl_cmd;
    alsd_pkg::dp_status_t dp_status;

    alsd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .status    (dp_status),
        .cmd       (ctrl_cmd)
    );

    alsd_dp #(
        .MAX_LEDS (MAX_LEDS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .op         (cmd.op),
        .led_index  (cmd.led_index),
        .red        (cmd.red),
        .green      (cmd.green),
        .blue       (cmd.blue),
        .cmd        (ctrl_cmd),
        .status     (dp_status),
        .line_level (res.line_level),
        .busy_res   (res.busy_res),
        .rejected   (res.rejected)
    );

endmodule

/* sv/alsd_ram.sv */
// generic single-port-write ram with registered read
module alsd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/alsd_ctrl.sv */
// controller state machine of the led strip driver
module alsd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  alsd_pkg::dp_status_t status,
    output alsd_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [5:0] {
        S_INIT  = 6'b000001,
        S_IDLE  = 6'b000010,
        S_FETCH = 6'b000100,
        S_LOAD  = 6'b001000,
        S_CLEAR = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_INIT:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.exec = 1'b1;
                    if (status.start_clear)
                    begin
                        state_next = S_CLEAR;
                    end
                    else if (status.need_fetch)
                    begin
                        state_next = S_FETCH;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_FETCH:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.load_row = 1'b1;
                state_next   = S_DONE;
            end
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef NO_ASSERTIONS
    a_fetch_then_load: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FETCH |=> state_reg == S_LOAD)
        else $error("row fetch not followed by row load");

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("pending result overwritten");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result raised outside done state");

    a_one_step_per_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.exec, cmd.load_row, cmd.clr_step, cmd.out_load}) <= 1)
        else $error("more than one datapath command at once");
`endif

endmodule

/* sv/alsd_dp.sv */
// datapath: config registers, frame buffer, bit timing and result register
module alsd_dp #(
    parameter int MAX_LEDS = alsd_pkg::MAX_LEDS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [alsd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [alsd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic [1:0]                      op,
    input  logic [7:0]                      led_index,
    input  logic [7:0]                      red,
    input  logic [7:0]                      green,
    input  logic [7:0]                      blue,
    input  alsd_pkg::ctrl_cmd_t             cmd,
    output alsd_pkg::dp_status_t            status,
    output logic                            line_level,
    output logic                            busy_res,
    output logic                            rejected
);

    localparam int AW  = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int CWM = $clog2(MAX_LEDS + 1);
    localparam int CW  = (CWM > 9) ? CWM : 9;
    localparam int RW  = alsd_pkg::ROW_W;

    function automatic logic pick_bit(input logic [RW-1:0] row, input logic [1:0] sel,
                                      input logic [2:0] bitp);
        logic [7:0] byt;
        case (sel)
            2'd0:    byt = row[23:16];
            2'd1:    byt = row[15:8];
            default: byt = row[7:0];
        endcase
        return byt[bitp];
    endfunction

    // configuration
    logic [1:0]  order_reg;
    logic [8:0]  count_reg;
    logic [7:0]  zh_reg;
    logic [7:0]  zl_reg;
    logic [7:0]  oh_reg;
    logic [7:0]  ol_reg;
    logic [15:0] latch_reg;

    // show sequencing
    alsd_pkg::phase_t phase_reg, phase_next;
    logic [CW-1:0]    led_ptr_reg, led_ptr_next;
    logic [1:0]       byte_sel_reg, byte_sel_next;
    logic [2:0]       bit_ptr_reg, bit_ptr_next;
    logic [15:0]      tick_reg, tick_next;
    logic             half_reg, half_next;
    logic             line_reg, line_next;
    logic             rej_reg, rej_next;
    logic [RW-1:0]    row_reg, row_next;
    logic [AW-1:0]    clr_cnt_reg, clr_cnt_next;
    logic             out_line_reg;
    logic             out_busy_reg;
    logic             out_rej_reg;

    logic [CW-1:0] count_ext;
    logic [CW-1:0] active;
    logic [CW-1:0] idx_ext;
    logic          busy;
    logic [15:0]   tick_dec;
    logic          fire;
    logic [CW-1:0] nb_led;
    logic [1:0]    nb_byte;
    logic [2:0]    nb_bit;
    logic          new_led;
    logic [RW-1:0] set_row;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [RW-1:0] ram_wdata;
    logic [RW-1:0] ram_rdata;
    logic          set_we;

    assign count_ext = CW'(count_reg);
    assign active    = (count_ext > CW'(MAX_LEDS)) ? CW'(MAX_LEDS) : count_ext;
    assign idx_ext   = CW'(led_index);
    assign busy      = (phase_reg != alsd_pkg::PH_IDLE);
    assign tick_dec  = (tick_reg == 16'd0) ? 16'd0 : tick_reg - 16'd1;
    assign fire      = (tick_dec == 16'd0);

    always_comb
    begin
        case (order_reg)
            alsd_pkg::ORDER_RGB: set_row = {red, green, blue};
            alsd_pkg::ORDER_GRB: set_row = {green, red, blue};
            alsd_pkg::ORDER_BGR: set_row = {blue, green, red};
            default:             set_row = '0;
        endcase
    end

    // pointers of the bit after the current one
    always_comb
    begin
        nb_led  = led_ptr_reg;
        nb_byte = byte_sel_reg;
        nb_bit  = bit_ptr_reg - 3'd1;
        new_led = 1'b0;
        if (bit_ptr_reg == 3'd0)
        begin
            nb_bit = 3'd7;
            if (byte_sel_reg == 2'd2)
            begin
                nb_byte = 2'd0;
                nb_led  = led_ptr_reg + CW'(1);
                new_led = 1'b1;
            end
            else
            begin
                nb_byte = byte_sel_reg + 2'd1;
            end
        end
    end

    always_comb
    begin
        phase_next         = phase_reg;
        led_ptr_next       = led_ptr_reg;
        byte_sel_next      = byte_sel_reg;
        bit_ptr_next       = bit_ptr_reg;
        tick_next          = tick_reg;
        half_next          = half_reg;
        line_next          = line_reg;
        rej_next           = rej_reg;
        row_next           = row_reg;
        clr_cnt_next       = clr_cnt_reg;
        status.need_fetch  = 1'b0;
        status.start_clear = 1'b0;
        status.clr_last    = (clr_cnt_reg == AW'(MAX_LEDS - 1));
        set_we             = 1'b0;
        if (cmd.exec)
        begin
            rej_next = 1'b0;
            if (op == alsd_pkg::OP_TICK)
            begin
                if (busy)
                begin
                    tick_next = tick_dec;
                    if (fire)
                    begin
                        case (phase_reg)
                            alsd_pkg::PH_PRE:
                            begin
                                if (active == CW'(0))
                                begin
                                    phase_next = alsd_pkg::PH_POST;
                                    line_next  = 1'b0;
                                    tick_next  = latch_reg;
                                end
                                else
                                begin
                                    phase_next        = alsd_pkg::PH_BITS;
                                    led_ptr_next      = '0;
                                    byte_sel_next     = 2'd0;
                                    bit_ptr_next      = 3'd7;
                                    half_next         = 1'b0;
                                    line_next         = 1'b1;
                                    status.need_fetch = 1'b1;
                                end
                            end
                            alsd_pkg::PH_BITS:
                            begin
                                if (!half_reg)
                                begin
                                    half_next = 1'b1;
                                    line_next = 1'b0;
                                    tick_next = pick_bit(row_reg, byte_sel_reg, bit_ptr_reg)
                                                ? 16'(ol_reg) : 16'(zl_reg);
                                end
                                else
                                begin
                                    led_ptr_next  = nb_led;
                                    byte_sel_next = nb_byte;
                                    bit_ptr_next  = nb_bit;
                                    if (new_led && nb_led >= active)
                                    begin
                                        phase_next = alsd_pkg::PH_POST;
                                        line_next  = 1'b0;
                                        tick_next  = latch_reg;
                                    end
                                    else
                                    begin
                                        half_next         = 1'b0;
                                        line_next         = 1'b1;
                                        status.need_fetch = new_led;
                                        tick_next = pick_bit(row_reg, nb_byte, nb_bit)
                                                    ? 16'(oh_reg) : 16'(zh_reg);
                                    end
                                end
                            end
                            alsd_pkg::PH_POST:
                            begin
                                phase_next = alsd_pkg::PH_IDLE;
                                line_next  = 1'b1;
                                tick_next  = 16'd0;
                            end
                            default:
                            begin
                                phase_next = phase_reg;
                            end
                        endcase
                    end
                end
            end
            else if (busy)
            begin
                rej_next = 1'b1;
            end
            else
            begin
                case (op)
                    alsd_pkg::OP_SET:
                    begin
                        if (idx_ext >= active)
                        begin
                            rej_next = 1'b1;
                        end
                        else
                        begin
                            set_we = 1'b1;
                        end
                    end
                    alsd_pkg::OP_CLEAR:
                    begin
                        status.start_clear = 1'b1;
                        clr_cnt_next       = '0;
                    end
                    default:
                    begin
                        phase_next    = alsd_pkg::PH_PRE;
                        line_next     = 1'b0;
                        tick_next     = latch_reg;
                        led_ptr_next  = '0;
                        byte_sel_next = 2'd0;
                        bit_ptr_next  = 3'd7;
                        half_next     = 1'b0;
                    end
                endcase
            end
        end
        if (cmd.load_row)
        begin
            row_next  = ram_rdata;
            tick_next = pick_bit(ram_rdata, byte_sel_reg, bit_ptr_reg)
                        ? 16'(oh_reg) : 16'(zh_reg);
        end
        if (cmd.clr_step)
        begin
            clr_cnt_next = clr_cnt_reg + AW'(1);
        end
    end

    assign ram_we    = set_we | cmd.clr_step;
    assign ram_waddr = cmd.clr_step ? clr_cnt_reg : idx_ext[AW-1:0];
    assign ram_wdata = cmd.clr_step ? '0 : set_row;

    alsd_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_LEDS)
    ) u_frame_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (led_ptr_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= alsd_pkg::RST_COLOR_ORDER;
            count_reg <= alsd_pkg::RST_LED_COUNT;
            zh_reg    <= alsd_pkg::RST_ZERO_HIGH;
            zl_reg    <= alsd_pkg::RST_ZERO_LOW;
            oh_reg    <= alsd_pkg::RST_ONE_HIGH;
            ol_reg    <= alsd_pkg::RST_ONE_LOW;
            latch_reg <= alsd_pkg::RST_LATCH;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                alsd_pkg::REG_COLOR_ORDER: order_reg <= cfg_wdata[1:0];
                alsd_pkg::REG_LED_COUNT:   count_reg <= cfg_wdata[8:0];
                alsd_pkg::REG_ZERO_HIGH:   zh_reg    <= cfg_wdata[7:0];
                alsd_pkg::REG_ZERO_LOW:    zl_reg    <= cfg_wdata[7:0];
                alsd_pkg::REG_ONE_HIGH:    oh_reg    <= cfg_wdata[7:0];
                alsd_pkg::REG_ONE_LOW:     ol_reg    <= cfg_wdata[7:0];
                alsd_pkg::REG_LATCH:       latch_reg <= cfg_wdata;
                default:                   latch_reg <= latch_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= alsd_pkg::PH_IDLE;
            led_ptr_reg  <= '0;
            byte_sel_reg <= 2'd0;
            bit_ptr_reg  <= 3'd7;
            tick_reg     <= 16'd0;
            half_reg     <= 1'b0;
            line_reg     <= 1'b0;
            rej_reg      <= 1'b0;
            clr_cnt_reg  <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            led_ptr_reg  <= led_ptr_next;
            byte_sel_reg <= byte_sel_next;
            bit_ptr_reg  <= bit_ptr_next;
            tick_reg     <= tick_next;
            half_reg     <= half_next;
            line_reg     <= line_next;
            rej_reg      <= rej_next;
            clr_cnt_reg  <= clr_cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        row_reg <= row_next;
        if (cmd.out_load)
        begin
            out_line_reg <= line_reg;
            out_busy_reg <= busy;
            out_rej_reg  <= rej_reg;
        end
    end

    assign line_level = out_line_reg;
    assign busy_res   = out_busy_reg;
    assign rejected   = out_rej_reg;

endmodule
